// File: src/label_canonical_form_under_permutations_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for label_canonical_form_under_permutations
// Shorthand for clocked implications with async active-low reset.
// ----------------------------------------------------------------------------
`ifndef LABEL_CANONICAL_FORM_UNDER_PERMUTATIONS_MACROS_SVH
`define LABEL_CANONICAL_FORM_UNDER_PERMUTATIONS_MACROS_SVH

// same-cycle implication
`define LCFP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LCFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/lcfp_pkg.sv
// ----------------------------------------------------------------------------
// lcfp_pkg
// Shared widths, codes and types of the canonical labeling block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcfp_pkg;

  localparam int unsigned MaxSitesDef    = 16;
  localparam int unsigned MaxRowsDef     = 64;
  localparam int unsigned SpeciesBitsDef = 4;

  localparam int unsigned RowW      = 6;
  localparam int unsigned SiteW     = 4;
  localparam int unsigned SpecW     = 4;
  localparam int unsigned SitesCfgW = 5;
  localparam int unsigned RowsCfgW  = 7;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 7;
  localparam int unsigned FixW      = 7;

  localparam logic [FixW-1:0] FixMax = 7'd127;

  typedef enum logic {
    FUNC_TABLE = 1'b0,
    FUNC_LABEL = 1'b1
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SITES = 8'd0,
    CFG_ROWS  = 8'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMP_EQ = 2'd0,
    CMP_LT = 2'd1,
    CMP_GT = 2'd2
  } cmp_e;

  // commands from control to the scan engine
  typedef struct packed {
    logic tab_we;
    logic lab_we;
    logic start;
  } eng_cmd_t;

endpackage

// File: src/lcfp_intf.sv
// ----------------------------------------------------------------------------
// lcfp channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lcfp_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [5:0] row;
  logic [3:0] site;
  logic [3:0] source_site;
  logic [3:0] species;
  modport source(output valid, func, row, site, source_site, species, input ready);
  modport sink(input valid, func, row, site, source_site, species, output ready);
endinterface

interface lcfp_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] out_site;
  logic [3:0] out_species;
  logic       all_distinct;
  logic       last;
  modport source(output valid, out_site, out_species, all_distinct, last, input ready);
  modport sink(input valid, out_site, out_species, all_distinct, last, output ready);
endinterface

interface lcfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [6:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: src/label_canonical_form_under_permutations.sv
// ----------------------------------------------------------------------------
// label_canonical_form_under_permutations
// Lexicographically smallest image of a labeling under a permutation table.
// ----------------------------------------------------------------------------
// Table items (func 0) load one permutation entry each.
// Label items (func 1) store one site; the item for site sites_in_use-1
// starts a scan: every row is read from the table RAM one site per cycle
// through a three-stage read pipeline (table read, labeling and best-image
// read, compare and candidate write), and the first read of the next row
// waits until the pipeline has drained after the last read of a row, so
// the next row compares against the updated best image. The smaller image
// wins by swapping two banks of the best-image RAM.
// Results leave one site at a time (read, then load) while the sink is ready;
// input is taken again once the last result sits in the output register.
// all_distinct is set when exactly one row maps the labeling onto itself.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "label_canonical_form_under_permutations_macros.svh"

module label_canonical_form_under_permutations
  import lcfp_pkg::*;
#(
  parameter int unsigned MAX_SITES    = MaxSitesDef,
  parameter int unsigned MAX_ROWS     = MaxRowsDef,
  parameter int unsigned SPECIES_BITS = SpeciesBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lcfp_in_if.sink   in_i,
  lcfp_cfg_if.sink  cfg_i,
  lcfp_out_if.source out_o
);

  localparam int unsigned SW = $clog2(MAX_SITES);
  localparam int unsigned NW = $clog2(MAX_SITES + 1);
  localparam int unsigned RW = $clog2(MAX_ROWS + 1);
  localparam int unsigned SB = SPECIES_BITS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_RD   = 4'b0100,
    ST_LD   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [SitesCfgW-1:0] sites_q;
  logic [RowsCfgW-1:0]  rows_q;
  logic [NW-1:0]        n;
  logic [RW-1:0]        rows;
  logic [SW-1:0]        k_q, k_d;

  logic             in_acc, lab_ok, load, k_last;
  eng_cmd_t         cmd;
  logic             busy, flag;
  logic [SB-1:0]    rd_spec;

  logic             out_v_q;
  logic [3:0]       out_site_q, out_spec_q;
  logic             out_flag_q, out_last_q;

  // clamp the registers into their usable ranges
  always_comb begin
    if (sites_q == '0) n = NW'(1);
    else if (32'(sites_q) > MAX_SITES) n = NW'(MAX_SITES);
    else n = NW'(sites_q);
    if (rows_q == '0) rows = RW'(1);
    else if (32'(rows_q) > MAX_ROWS) rows = RW'(MAX_ROWS);
    else rows = RW'(rows_q);
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sites_q <= SitesCfgW'(16);
      rows_q  <= RowsCfgW'(64);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SITES: sites_q <= SitesCfgW'(cfg_i.data);
        CFG_ROWS:  rows_q  <= RowsCfgW'(cfg_i.data);
        default:   ;
      endcase
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign lab_ok     = (in_i.func == FUNC_LABEL) && (NW'(in_i.site) < n)
                      && (32'(in_i.site) < MAX_SITES);

  assign cmd.tab_we = in_acc && (in_i.func == FUNC_TABLE);
  assign cmd.lab_we = in_acc && lab_ok;
  assign cmd.start  = cmd.lab_we && (NW'(in_i.site) == n - NW'(1));

  lcfp_engine #(
    .MAX_SITES(MAX_SITES), .MAX_ROWS(MAX_ROWS), .SPECIES_BITS(SPECIES_BITS)
  ) u_engine (
    .clk_i, .rst_ni,
    .cmd_i(cmd),
    .tab_row_i(in_i.row),
    .wr_site_i(in_i.site),
    .tab_src_i(in_i.source_site),
    .lab_spec_i(SB'(in_i.species)),
    .n_i(n),
    .rows_i(rows),
    .rd_k_i(k_q),
    .busy_o(busy),
    .rd_spec_o(rd_spec),
    .flag_o(flag)
  );

  // emission: read best image at k, then move it into the output register
  assign k_last = (NW'(k_q) == n - NW'(1));
  assign load   = (state_q == ST_LD) && (!out_v_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    case (state_q)
      ST_IDLE: if (cmd.start) state_d = ST_RUN;
      ST_RUN: begin
        k_d = '0;
        if (!busy) state_d = ST_RD;
      end
      ST_RD: state_d = ST_LD;
      ST_LD: begin
        if (load) begin
          if (k_last) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + SW'(1);
            state_d = ST_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (load) out_v_q <= 1'b1;
      else if (out_o.ready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_site_q <= 4'(k_q);
      out_spec_q <= 4'(rd_spec);
      out_flag_q <= flag;
      out_last_q <= k_last;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.out_site     = out_site_q;
  assign out_o.out_species  = out_spec_q;
  assign out_o.all_distinct = out_flag_q;
  assign out_o.last         = out_last_q;

  `LCFP_ASSERT_SAME(a_busy_in_run, clk_i, rst_ni, busy, state_q == ST_RUN, "scan outside run")
  `LCFP_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, cmd.start, busy, "scan did not start")
  `LCFP_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, load && k_last,
                    state_q == ST_IDLE && out_o.last, "last result not closing")

endmodule

// File: src/lcfp_ram.sv
// ----------------------------------------------------------------------------
// lcfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcfp_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/lcfp_engine.sv
// ----------------------------------------------------------------------------
// lcfp_engine
// Holds table, labeling and best image RAMs; scans all rows site by site.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcfp_engine
  import lcfp_pkg::*;
#(
  parameter int unsigned MAX_SITES    = MaxSitesDef,
  parameter int unsigned MAX_ROWS     = MaxRowsDef,
  parameter int unsigned SPECIES_BITS = SpeciesBitsDef,
  localparam int unsigned SW  = $clog2(MAX_SITES),
  localparam int unsigned NW  = $clog2(MAX_SITES + 1),
  localparam int unsigned RW  = $clog2(MAX_ROWS + 1),
  localparam int unsigned SB  = SPECIES_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  eng_cmd_t         cmd_i,
  input  logic [RowW-1:0]  tab_row_i,
  input  logic [SiteW-1:0] wr_site_i,
  input  logic [SiteW-1:0] tab_src_i,
  input  logic [SB-1:0]    lab_spec_i,
  input  logic [NW-1:0]    n_i,
  input  logic [RW-1:0]    rows_i,
  input  logic [SW-1:0]    rd_k_i,
  output logic             busy_o,
  output logic [SB-1:0]    rd_spec_o,
  output logic             flag_o
);

  localparam int unsigned TD  = MAX_ROWS * MAX_SITES;
  localparam int unsigned TAW = $clog2(TD);
  localparam int unsigned RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned BD  = 2 * (1 << SW);

  // issue stage
  logic            run_q, iss_q;
  logic [RIW-1:0]  ir_q;
  logic [SW-1:0]   ik_q;
  logic [TAW-1:0]  base_q;
  // pipeline
  logic            s1_v_q, s2_v_q;
  logic [SW-1:0]   s1_k_q, s2_k_q;
  logic            s1_last_q, s2_last_q, s2_oor_q;
  // row state
  cmp_e            cmp_q, cur_cmp, nxt_cmp;
  logic            same_q, same_cur, same_nxt;
  logic            have_q, bank_q;
  logic [FixW-1:0] fix_q;

  logic [SiteW-1:0] perm_rd;
  logic [SB-1:0]    laba_rd, labb_rd, best_rd, img;
  logic             tab_ok;
  logic [TAW-1:0]   tab_waddr, perm_raddr;
  logic [SW:0]      best_raddr;
  logic             ik_last, row_done;

  assign tab_ok    = (32'(tab_row_i) < MAX_ROWS) && (32'(wr_site_i) < MAX_SITES);
  assign tab_waddr = TAW'(32'(tab_row_i) * MAX_SITES + 32'(wr_site_i));
  assign perm_raddr = TAW'(32'(base_q) + 32'(ik_q));
  assign ik_last   = (NW'(ik_q) == n_i - NW'(1));
  assign row_done  = run_q && !iss_q && !s1_v_q && !s2_v_q;

  lcfp_ram #(.WIDTH(SiteW), .DEPTH(TD)) u_perm (
    .clk_i, .we_i(cmd_i.tab_we && tab_ok), .waddr_i(tab_waddr), .wdata_i(tab_src_i),
    .raddr_i(perm_raddr), .rdata_o(perm_rd)
  );

  // two copies of the labeling: one read through the permutation, one in order
  lcfp_ram #(.WIDTH(SB), .DEPTH(MAX_SITES)) u_lab_a (
    .clk_i, .we_i(cmd_i.lab_we), .waddr_i(SW'(wr_site_i)), .wdata_i(lab_spec_i),
    .raddr_i(SW'(perm_rd)), .rdata_o(laba_rd)
  );

  lcfp_ram #(.WIDTH(SB), .DEPTH(MAX_SITES)) u_lab_b (
    .clk_i, .we_i(cmd_i.lab_we), .waddr_i(SW'(wr_site_i)), .wdata_i(lab_spec_i),
    .raddr_i(s1_k_q), .rdata_o(labb_rd)
  );

  // best image in one bank, candidate written into the other
  assign best_raddr = run_q ? {bank_q, s1_k_q} : {bank_q, rd_k_i};

  lcfp_ram #(.WIDTH(SB), .DEPTH(BD)) u_best (
    .clk_i, .we_i(s2_v_q), .waddr_i({~bank_q, s2_k_q}), .wdata_i(img),
    .raddr_i(best_raddr), .rdata_o(best_rd)
  );

  assign img = s2_oor_q ? '0 : laba_rd;

  always_comb begin
    cur_cmp  = (s2_k_q == '0) ? CMP_EQ : cmp_q;
    same_cur = (s2_k_q == '0) ? 1'b1 : same_q;
    same_nxt = same_cur && (img == labb_rd);
    case (cur_cmp)
      CMP_EQ: begin
        if (img < best_rd) nxt_cmp = CMP_LT;
        else if (img > best_rd) nxt_cmp = CMP_GT;
        else nxt_cmp = CMP_EQ;
      end
      default: nxt_cmp = cur_cmp;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      iss_q  <= 1'b0;
      ir_q   <= '0;
      ik_q   <= '0;
      base_q <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      cmp_q  <= CMP_EQ;
      same_q <= 1'b0;
      have_q <= 1'b0;
      bank_q <= 1'b0;
      fix_q  <= '0;
    end else begin
      s1_v_q <= iss_q;
      s2_v_q <= s1_v_q;
      if (cmd_i.start) begin
        run_q  <= 1'b1;
        iss_q  <= 1'b1;
        ir_q   <= '0;
        ik_q   <= '0;
        base_q <= '0;
        have_q <= 1'b0;
        fix_q  <= '0;
      end else if (iss_q) begin
        if (ik_last) iss_q <= 1'b0;
        else ik_q <= ik_q + SW'(1);
      end else if (row_done) begin
        if (RW'(ir_q) == rows_i - RW'(1)) begin
          run_q <= 1'b0;
        end else begin
          ir_q   <= ir_q + RIW'(1);
          base_q <= TAW'(32'(base_q) + MAX_SITES);
          ik_q   <= '0;
          iss_q  <= 1'b1;
        end
      end
      if (s2_v_q) begin
        cmp_q  <= nxt_cmp;
        same_q <= same_nxt;
        if (s2_last_q) begin
          if (!have_q || nxt_cmp == CMP_LT) begin
            bank_q <= ~bank_q;
            have_q <= 1'b1;
          end
          if (same_nxt && fix_q != FixMax) fix_q <= fix_q + FixW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_k_q    <= ik_q;
    s1_last_q <= ik_last;
    s2_k_q    <= s1_k_q;
    s2_last_q <= s1_last_q;
    s2_oor_q  <= (NW'(perm_rd) >= n_i) || (32'(perm_rd) >= MAX_SITES);
  end

  assign busy_o    = run_q;
  assign rd_spec_o = best_rd;
  assign flag_o    = (fix_q == FixW'(1));

endmodule
